FILE: design/skcu_pkg.sv
`default_nettype none

package skcu_pkg;

    // Width of every item and result field on the ports
    localparam int FIELD_W = 10;

    // Reset value of the person count register
    localparam logic [FIELD_W-1:0] PERSON_COUNT_RESET = 10'd1023;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_LINK,
        ST_MERGE_A,
        ST_MERGE_B,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;   // write one entry of the reset sweep
        logic accept;       // latch item, read parent of person and key owner
        logic invalid_res;  // stage the empty result of a rejected item
        logic walk_step;    // follow one parent link toward the root
        logic root_found;   // latch root, restart at the start node
        logic comp_step;    // point current node at root, move on
        logic start_owner;  // begin second find at the key owner
        logic own_write;    // record person as owner of key
        logic prep_plain;   // stage a no-merge result
        logic merge_a;      // write new size at winner root
        logic merge_b;      // hang loser root under winner
        logic load_out;     // move staged result to the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic item_ok;
        logic rd_nonneg;
        logic comp_go;
        logic phase_second;
        logic owner_zero;
        logic same_root;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: design/shared_key_cluster_union.sv
// One item at a time; the next transfer is taken in IDLE once DONE has loaded the result.
// Pace is set by the single read port of the parent store, one hop per cycle.
// Reset: a clearing pass over max(MAX_PERSONS, MAX_KEYS) entries, item_ready low;
// person_count resets to 1023 and config writes are taken during the pass.
`default_nettype none

module shared_key_cluster_union #(
    parameter int MAX_PERSONS = 1024,
    parameter int MAX_KEYS    = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [9:0]  person,
    input  wire logic [9:0]  key,
    // result channel
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic      [9:0]  root,
    output logic      [9:0]  cluster_size,
    output logic      [9:0]  cluster_count,
    output logic             merged,
    // person count register
    input  wire logic        cfg_write_en,
    input  wire logic [9:0]  cfg_write_data
);

    // The controller sequences each valid transfer:
    //   find root of person (walk up, then compress the same path),
    //   claim the key if unowned, otherwise find the owner's root the same way
    //   and, if the roots differ, union by size (ties keep the person's root).
    // The datapath holds both stores, the walk registers and the output
    // register, so a finished result can wait while the next item is taken.
    skcu_pkg::cmd_t    cmd;
    skcu_pkg::status_t status;

    skcu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    skcu_datapath #(
        .MAX_PERSONS (MAX_PERSONS),
        .MAX_KEYS    (MAX_KEYS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .person         (person),
        .key            (key),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .root           (root),
        .cluster_size   (cluster_size),
        .cluster_count  (cluster_count),
        .merged         (merged),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

FILE: design/skcu_ram.sv
`default_nettype none

module skcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/skcu_ctrl.sv
`default_nettype none

module skcu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire skcu_pkg::status_t status,
    output skcu_pkg::cmd_t         cmd
);

    skcu_pkg::state_t state_reg;
    skcu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skcu_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            skcu_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = skcu_pkg::ST_IDLE;
                end
            end
            skcu_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.item_ok)
                    begin
                        state_next = skcu_pkg::ST_FIND;
                    end
                    else
                    begin
                        cmd.invalid_res = 1'b1;
                        state_next      = skcu_pkg::ST_DONE;
                    end
                end
            end
            skcu_pkg::ST_FIND:
            begin
                if (status.rd_nonneg)
                begin
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    cmd.root_found = 1'b1;
                    state_next     = skcu_pkg::ST_COMP;
                end
            end
            skcu_pkg::ST_COMP:
            begin
                if (status.comp_go)
                begin
                    cmd.comp_step = 1'b1;
                end
                else
                begin
                    state_next = skcu_pkg::ST_LINK;
                end
            end
            skcu_pkg::ST_LINK:
            begin
                if (!status.phase_second)
                begin
                    if (status.owner_zero)
                    begin
                        cmd.own_write  = 1'b1;
                        cmd.prep_plain = 1'b1;
                        state_next     = skcu_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.start_owner = 1'b1;
                        state_next      = skcu_pkg::ST_FIND;
                    end
                end
                else if (status.same_root)
                begin
                    cmd.prep_plain = 1'b1;
                    state_next     = skcu_pkg::ST_DONE;
                end
                else
                begin
                    cmd.merge_a = 1'b1;
                    state_next  = skcu_pkg::ST_MERGE_B;
                end
            end
            skcu_pkg::ST_MERGE_A:
            begin
                // merge normally enters through LINK; kept for a complete decode
                cmd.merge_a = 1'b1;
                state_next  = skcu_pkg::ST_MERGE_B;
            end
            skcu_pkg::ST_MERGE_B:
            begin
                cmd.merge_b = 1'b1;
                state_next  = skcu_pkg::ST_DONE;
            end
            skcu_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = skcu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skcu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/skcu_datapath.sv
`default_nettype none

module skcu_datapath #(
    parameter int MAX_PERSONS = 1024,
    parameter int MAX_KEYS    = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [skcu_pkg::FIELD_W-1:0]  person,
    input  wire logic [skcu_pkg::FIELD_W-1:0]  key,
    input  wire logic                          cfg_write_en,
    input  wire logic [skcu_pkg::FIELD_W-1:0]  cfg_write_data,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic      [skcu_pkg::FIELD_W-1:0]  root,
    output logic      [skcu_pkg::FIELD_W-1:0]  cluster_size,
    output logic      [skcu_pkg::FIELD_W-1:0]  cluster_count,
    output logic                               merged,
    input  wire skcu_pkg::cmd_t                cmd,
    output skcu_pkg::status_t                  status
);

    localparam int FW        = skcu_pkg::FIELD_W;
    localparam int AW        = $clog2(MAX_PERSONS);
    localparam int PW        = AW + 1;   // parent index, or minus size at a root
    localparam int KW        = $clog2(MAX_KEYS);
    localparam int CLR_DEPTH = (MAX_PERSONS > MAX_KEYS) ? MAX_PERSONS : MAX_KEYS;
    localparam int CLW       = $clog2(CLR_DEPTH);

    // parent store ports
    logic          p_we;
    logic [AW-1:0] p_wa;
    logic [PW-1:0] p_wd;
    logic          p_re;
    logic [AW-1:0] p_ra;
    logic [PW-1:0] p_rd;

    // owner store ports
    logic          o_we;
    logic [KW-1:0] o_wa;
    logic [AW-1:0] o_wd;
    logic          o_re;
    logic [KW-1:0] o_ra;
    logic [AW-1:0] o_rd;

    logic [CLW-1:0] clr_cnt_reg;
    logic [AW-1:0]  person_reg;
    logic [KW-1:0]  key_reg;
    logic [AW-1:0]  cur_reg;
    logic [AW-1:0]  start_reg;
    logic           phase_reg;
    logic [AW-1:0]  root_reg;
    logic [PW-1:0]  root_val_reg;
    logic [AW-1:0]  other_reg;
    logic [PW-1:0]  other_val_reg;
    logic [AW-1:0]  res_root_reg;
    logic [PW-1:0]  res_size_reg;
    logic           res_merged_reg;
    logic [FW-1:0]  merge_count_reg;
    logic [FW-1:0]  person_count_reg;
    logic           out_valid_reg;
    logic [FW-1:0]  out_root_reg;
    logic [FW-1:0]  out_size_reg;
    logic [FW-1:0]  out_count_reg;
    logic           out_merged_reg;

    logic [AW-1:0] found_root;
    logic [AW-1:0] rd_link;
    logic          r_small;
    logic [PW-1:0] size_sum;
    logic [AW-1:0] win_root;
    logic [AW-1:0] lose_root;
    logic [FW-1:0] clusters_left;

    skcu_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_PERSONS)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_wa),
        .wr_data (p_wd),
        .rd_en   (p_re),
        .rd_addr (p_ra),
        .rd_data (p_rd)
    );

    skcu_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_KEYS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (o_we),
        .wr_addr (o_wa),
        .wr_data (o_wd),
        .rd_en   (o_re),
        .rd_addr (o_ra),
        .rd_data (o_rd)
    );

    assign found_root = phase_reg ? other_reg : root_reg;
    assign rd_link    = p_rd[AW-1:0];
    // roots hold minus size: the greater value is the smaller set
    assign r_small    = $signed(root_val_reg) > $signed(other_val_reg);
    assign size_sum   = root_val_reg + other_val_reg;
    assign win_root   = r_small ? other_reg : root_reg;
    assign lose_root  = (res_root_reg == root_reg) ? other_reg : root_reg;
    assign clusters_left = (person_count_reg >= merge_count_reg) ?
                           (person_count_reg - merge_count_reg) : '0;

    always_comb
    begin
        status.clear_last   = (clr_cnt_reg == CLW'(CLR_DEPTH - 1));
        status.item_ok      = (person != '0) && (person <= person_count_reg) &&
                              (32'(person) < MAX_PERSONS) && (32'(key) < MAX_KEYS);
        status.rd_nonneg    = !p_rd[PW-1];
        status.comp_go      = (cur_reg != found_root) && !p_rd[PW-1];
        status.phase_second = phase_reg;
        status.owner_zero   = (o_rd == '0);
        status.same_root    = (other_reg == root_reg);
        status.out_free     = !out_valid_reg || result_ready;
    end

    always_comb
    begin
        p_we = 1'b0;
        p_wa = cur_reg;
        p_wd = PW'(found_root);
        if (cmd.clear_step)
        begin
            p_we = (32'(clr_cnt_reg) < MAX_PERSONS);
            p_wa = clr_cnt_reg[AW-1:0];
            p_wd = '1;
        end
        else if (cmd.comp_step)
        begin
            p_we = 1'b1;
        end
        else if (cmd.merge_a)
        begin
            p_we = 1'b1;
            p_wa = win_root;
            p_wd = size_sum;
        end
        else if (cmd.merge_b)
        begin
            p_we = 1'b1;
            p_wa = lose_root;
            p_wd = PW'(res_root_reg);
        end
    end

    always_comb
    begin
        p_re = cmd.accept | cmd.walk_step | cmd.root_found | cmd.comp_step |
               cmd.start_owner;
        p_ra = rd_link;
        if (cmd.accept)
        begin
            p_ra = AW'(person);
        end
        else if (cmd.root_found)
        begin
            p_ra = start_reg;
        end
        else if (cmd.start_owner)
        begin
            p_ra = o_rd;
        end
    end

    always_comb
    begin
        o_re = cmd.accept;
        o_ra = KW'(key);
        o_we = 1'b0;
        o_wa = key_reg;
        o_wd = person_reg;
        if (cmd.clear_step)
        begin
            o_we = (32'(clr_cnt_reg) < MAX_KEYS);
            o_wa = clr_cnt_reg[KW-1:0];
            o_wd = '0;
        end
        else if (cmd.own_write)
        begin
            o_we = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            phase_reg        <= 1'b0;
            merge_count_reg  <= '0;
            person_count_reg <= skcu_pkg::PERSON_COUNT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                phase_reg <= 1'b0;
            end
            else if (cmd.start_owner)
            begin
                phase_reg <= 1'b1;
            end
            if (cmd.merge_a && (merge_count_reg != '1))
            begin
                merge_count_reg <= merge_count_reg + 1'b1;
            end
            if (cfg_write_en)
            begin
                person_count_reg <= cfg_write_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            person_reg <= AW'(person);
            key_reg    <= KW'(key);
            cur_reg    <= AW'(person);
            start_reg  <= AW'(person);
        end
        if (cmd.walk_step || cmd.comp_step)
        begin
            cur_reg <= rd_link;
        end
        if (cmd.root_found)
        begin
            cur_reg <= start_reg;
            if (phase_reg)
            begin
                other_reg     <= cur_reg;
                other_val_reg <= p_rd;
            end
            else
            begin
                root_reg     <= cur_reg;
                root_val_reg <= p_rd;
            end
        end
        if (cmd.start_owner)
        begin
            start_reg <= o_rd;
            cur_reg   <= o_rd;
        end
        if (cmd.invalid_res)
        begin
            res_root_reg   <= '0;
            res_size_reg   <= '0;
            res_merged_reg <= 1'b0;
        end
        if (cmd.prep_plain)
        begin
            res_root_reg   <= root_reg;
            res_size_reg   <= PW'(0) - root_val_reg;
            res_merged_reg <= 1'b0;
        end
        if (cmd.merge_a)
        begin
            res_root_reg   <= win_root;
            res_size_reg   <= PW'(0) - size_sum;
            res_merged_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_root_reg   <= FW'(res_root_reg);
            out_size_reg   <= FW'(res_size_reg);
            out_count_reg  <= clusters_left;
            out_merged_reg <= res_merged_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign root          = out_root_reg;
    assign cluster_size  = out_size_reg;
    assign cluster_count = out_count_reg;
    assign merged        = out_merged_reg;

endmodule

`default_nettype wire
